@@ rtl/aaoc_pkg.sv @@
package aaoc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned StW   = 2;
  // shared adder: two guard bits above the data word
  localparam int unsigned AluW  = DataW + 2;
  localparam int unsigned CntW  = $clog2(DataW);

  typedef logic [OpW-1:0] op_t;
  typedef logic [StW-1:0] status_t;

  localparam op_t OP_ADD  = 3'd0;
  localparam op_t OP_SUB  = 3'd1;
  localparam op_t OP_MUL  = 3'd2;
  localparam op_t OP_DIV  = 3'd3;
  localparam op_t OP_STOP = 3'd4;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OVERFLOW = 2'd1;
  localparam status_t ST_DIVZERO  = 2'd2;
  localparam status_t ST_HALTED   = 2'd3;

endpackage

@@ rtl/accumulator_alu_overflow_check.sv @@
// Signed 32-bit accumulator calculator. Each input beat carries an operation in
// s_tuser_i (add, subtract, multiply, divide, stop; any other code stops) and a
// signed operand in s_tdata_i; the block combines the accumulator (zero after
// reset) with the operand and returns one beat with the new total and a status
// (ok, overflow, divide by zero, halted). Overflow is exact for all four
// operations, division truncates toward zero, and a zero divisor reports divide
// by zero unless the block is already halted. Any error or a stop leaves the total unchanged and halts the
// block: every later beat answers halted until reset. All arithmetic runs
// through one 34-bit adder/subtractor under a small sequencer, so one beat is
// accepted at a time. After the accepting state, stop, halted and divide-by-zero
// beats go straight to the result state; add and subtract pass through one
// add/subtract state; multiply and divide pass through two magnitude states, 32
// shift-add or restoring-divide steps of one bit each and a sign fix-up state
// before the result state. The result sits in an output register; a stalled
// master side holds the sequencer in its result state, and s_tready_o rises
// again once the result has been registered.
module accumulator_alu_overflow_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // slave side
  input  logic                       s_tvalid_i,
  output logic                       s_tready_o,
  input  logic [aaoc_pkg::DataW-1:0] s_tdata_i,  // [31:0] operand (signed)
  input  logic [aaoc_pkg::OpW-1:0]   s_tuser_i,  // [2:0] req_type
  // master side
  output logic                       m_tvalid_o,
  input  logic                       m_tready_i,
  output logic [aaoc_pkg::DataW-1:0] m_tdata_o,  // [31:0] new_total (signed)
  output logic [aaoc_pkg::StW-1:0]   m_tuser_o   // [1:0] status
);

  import aaoc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDSUB,
    S_ABS_A,
    S_ABS_B,
    S_ITER,
    S_FIX,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [DataW-1:0]    acc_q;      // accumulator, two's complement
  logic                halted_q;
  op_t                 op_q;
  logic [DataW-1:0]    opd_q;      // operand as received
  status_t             status_q;   // status of the beat in flight
  logic [DataW-1:0]    res_q;      // candidate new total
  logic [DataW:0]      hi_q;       // product high half or division remainder
  logic [DataW-1:0]    lo_q;       // multiplier / product low half, or dividend / quotient
  logic [DataW-1:0]    b_q;        // multiplicand or divisor magnitude
  logic                neg_q;      // result sign for multiply and divide
  logic [CntW-1:0]     cnt_q;
  logic                m_tvalid_q;
  logic [DataW-1:0]    m_tdata_q;
  status_t             m_tuser_q;

  // shared adder/subtractor
  logic [AluW-1:0]     alu_x;
  logic [AluW-1:0]     alu_y;
  logic                alu_sub;
  logic [AluW-1:0]     alu_sum;
  logic                is_mul;
  logic [DataW:0]      mul_hi;     // high half after the conditional add
  logic                out_free;

  assign is_mul   = (op_q == OP_MUL);
  assign out_free = !m_tvalid_q || m_tready_i;

  // operand selection for the one adder, by sequencer step
  always_comb begin
    alu_x   = '0;
    alu_y   = '0;
    alu_sub = 1'b0;
    case (state_q)
      S_ADDSUB: begin
        alu_x   = {{2{acc_q[DataW-1]}}, acc_q};
        alu_y   = {{2{opd_q[DataW-1]}}, opd_q};
        alu_sub = (op_q == OP_SUB);
      end
      S_ABS_A: begin
        // 0 +/- acc gives the magnitude
        alu_y   = {{2{acc_q[DataW-1]}}, acc_q};
        alu_sub = acc_q[DataW-1];
      end
      S_ABS_B: begin
        alu_y   = {{2{opd_q[DataW-1]}}, opd_q};
        alu_sub = opd_q[DataW-1];
      end
      S_ITER: begin
        alu_y = {2'b00, b_q};
        if (is_mul) begin
          alu_x = {1'b0, hi_q};
        end else begin
          // trial subtract of the shifted-in partial remainder
          alu_x   = {1'b0, hi_q[DataW-1:0], lo_q[DataW-1]};
          alu_sub = 1'b1;
        end
      end
      S_FIX: begin
        alu_y   = {2'b00, lo_q};
        alu_sub = neg_q;
      end
      default: begin
      end
    endcase
    alu_sum = alu_x + (alu_y ^ {AluW{alu_sub}}) + {{(AluW-1){1'b0}}, alu_sub};
  end

  assign mul_hi = lo_q[0] ? alu_sum[DataW:0] : hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      acc_q      <= '0;
      halted_q   <= 1'b0;
      status_q   <= ST_OK;
      cnt_q      <= '0;
      m_tvalid_q <= 1'b0;
      op_q       <= OP_ADD;
      opd_q      <= '0;
      res_q      <= '0;
      hi_q       <= '0;
      lo_q       <= '0;
      b_q        <= '0;
      neg_q      <= 1'b0;
      m_tdata_q  <= '0;
      m_tuser_q  <= ST_OK;
    end else begin
      // in the result cycle the output register is reloaded below
      if (m_tvalid_q && m_tready_i && state_q != S_DONE) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_tvalid_i) begin
            op_q  <= s_tuser_i;
            opd_q <= s_tdata_i;
            if (halted_q) begin
              status_q <= ST_HALTED;
              state_q  <= S_DONE;
            end else begin
              case (s_tuser_i)
                OP_ADD, OP_SUB: begin
                  status_q <= ST_OK;
                  state_q  <= S_ADDSUB;
                end
                OP_MUL: begin
                  status_q <= ST_OK;
                  state_q  <= S_ABS_A;
                end
                OP_DIV: begin
                  if (s_tdata_i == '0) begin
                    status_q <= ST_DIVZERO;
                    state_q  <= S_DONE;
                  end else begin
                    status_q <= ST_OK;
                    state_q  <= S_ABS_A;
                  end
                end
                default: begin
                  // stop and unknown codes
                  status_q <= ST_HALTED;
                  state_q  <= S_DONE;
                end
              endcase
            end
          end
        end
        S_ADDSUB: begin
          res_q <= alu_sum[DataW-1:0];
          // fits only if the top three bits agree
          if (!(alu_sum[AluW-1:DataW-1] == 3'b000 || alu_sum[AluW-1:DataW-1] == 3'b111)) begin
            status_q <= ST_OVERFLOW;
          end
          state_q <= S_DONE;
        end
        S_ABS_A: begin
          if (is_mul) begin
            b_q <= alu_sum[DataW-1:0];
          end else begin
            lo_q <= alu_sum[DataW-1:0];
          end
          neg_q   <= acc_q[DataW-1] ^ opd_q[DataW-1];
          hi_q    <= '0;
          state_q <= S_ABS_B;
        end
        S_ABS_B: begin
          if (is_mul) begin
            lo_q <= alu_sum[DataW-1:0];
          end else begin
            b_q <= alu_sum[DataW-1:0];
          end
          cnt_q   <= '0;
          state_q <= S_ITER;
        end
        S_ITER: begin
          if (is_mul) begin
            hi_q <= {1'b0, mul_hi[DataW:1]};
            lo_q <= {mul_hi[0], lo_q[DataW-1:1]};
          end else begin
            if (!alu_sum[AluW-1]) begin
              hi_q <= {1'b0, alu_sum[DataW-1:0]};
            end else begin
              hi_q <= {1'b0, hi_q[DataW-2:0], lo_q[DataW-1]};
            end
            lo_q <= {lo_q[DataW-2:0], ~alu_sum[AluW-1]};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DataW - 1)) begin
            state_q <= S_FIX;
          end
        end
        S_FIX: begin
          res_q <= alu_sum[DataW-1:0];
          // magnitude must be below 2^31, or exactly 2^31 for a negative result
          if ((is_mul && hi_q[DataW-1:0] != '0) ||
              (lo_q[DataW-1] && !(neg_q && lo_q[DataW-2:0] == '0))) begin
            status_q <= ST_OVERFLOW;
          end
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            m_tvalid_q <= 1'b1;
            m_tuser_q  <= status_q;
            if (status_q == ST_OK) begin
              acc_q     <= res_q;
              m_tdata_q <= res_q;
            end else begin
              halted_q  <= 1'b1;
              m_tdata_q <= acc_q;
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_tready_o = (state_q == S_IDLE);
  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;

`ifndef SYNTHESIS
  // once halted, only reset brings the block back
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared without reset");

  // the accumulator moves only when a result is registered
  a_acc_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DONE) |=> $stable(acc_q))
    else $error("accumulator changed outside the result cycle");

  // a halted block reports halted on every beat
  a_halted_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && halted_q) |-> (status_q == ST_HALTED))
    else $error("halted block produced a non-halted status");

  // step counter idles at zero outside the iteration
  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ITER) |-> (cnt_q == '0))
    else $error("step counter running outside iteration");

  // a successful result always becomes the new total
  a_ok_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_free && status_q == ST_OK) |=> (acc_q == m_tdata_q))
    else $error("ok result not committed to the accumulator");
`endif

endmodule
